FILE: design/spsi_pkg.sv
// Shared types, constants and helpers for the semi-implicit spectral update.
// Standalone package; used by spectral_semi_implicit_update_top.
package spsi_pkg;

  localparam logic [2:0] REG_KX_STEP     = 3'd0;
  localparam logic [2:0] REG_KY_STEP     = 3'd1;
  localparam logic [2:0] REG_TIME_STEP   = 3'd2;
  localparam logic [2:0] REG_MOBILITY    = 3'd3;
  localparam logic [2:0] REG_COEFF_OUTER = 3'd4;
  localparam logic [2:0] REG_COEFF_INNER = 3'd5;
  localparam logic [2:0] REG_BX_GAIN     = 3'd6;
  localparam logic [2:0] REG_GAUSS_INV_W = 3'd7;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic [30:0]        ONE_Q31 = 31'd65536;
  localparam logic [16:0]        LOG2E_Q = 17'd94548;
  localparam logic [16:0]        CHI_ONE = 17'd65536;
  localparam int                 DIV_BITS = 32;

  // per-item flags that ride along the divider stages
  typedef struct packed {
    logic       ov;
    logic       dz;
    logic       dneg;
    logic [1:0] nneg;
    logic [1:0] nzero;
    logic [1:0] ovq;
  } dv_side_t;

  typedef struct packed {
    logic signed [31:0] s_re;
    logic signed [31:0] s_im;
    logic signed [31:0] n_re;
    logic signed [31:0] n_im;
  } pay_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = S32_MAX;
    else if (v < -64'sd2147483648) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf_s32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic [30:0] sat_u31(input logic [63:0] v);
    return (|v[63:31]) ? 31'h7fff_ffff : v[30:0];
  endfunction

  // 2^(-j/16) in Q16.16, j = 0..16
  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] r;
    case (j)
      5'd0:  r = 17'd65536;
      5'd1:  r = 17'd62757;
      5'd2:  r = 17'd60097;
      5'd3:  r = 17'd57549;
      5'd4:  r = 17'd55109;
      5'd5:  r = 17'd52773;
      5'd6:  r = 17'd50535;
      5'd7:  r = 17'd48393;
      5'd8:  r = 17'd46341;
      5'd9:  r = 17'd44376;
      5'd10: r = 17'd42495;
      5'd11: r = 17'd40693;
      5'd12: r = 17'd38968;
      5'd13: r = 17'd37316;
      5'd14: r = 17'd35734;
      5'd15: r = 17'd34219;
      5'd16: r = 17'd32768;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage

FILE: design/spectral_semi_implicit_update_top.sv
// One item per cycle sustained while out_ready keeps the output register from stalling.
// Throughput is set by a fully pipelined datapath: stages A..M, then a
// 32-stage restoring divider (one quotient bit per stage, two lanes) and an output register.
// Reset (rst_n low, synchronous): all valid bits drop, config registers return to
// their defaults (mobility and gauss_inv_width 1.0, the rest 0). Data registers keep junk.
// Depends on spsi_pkg.
module spectral_semi_implicit_update_top
  import spsi_pkg::*;
#(
  parameter int GRID_Y = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration writes
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [9:0]         in_col_index,
  input  logic [9:0]         in_row_index,
  input  logic signed [31:0] in_spec_re,
  input  logic signed [31:0] in_spec_im,
  input  logic signed [31:0] in_nl_re,
  input  logic signed [31:0] in_nl_im,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_re,
  output logic signed [31:0] out_new_im,
  output logic               out_overflow
);

  // wrapped row magnitude needs to hold GRID_Y and any 10-bit row
  localparam int YK_W = ($clog2(GRID_Y + 1) > 10) ? $clog2(GRID_Y + 1) : 10;
  localparam int YW_W = YK_W + 1;
  localparam logic [YW_W-1:0] GRID_W = YW_W'(GRID_Y);
  localparam logic [YW_W-1:0] HALF_W = YW_W'(GRID_Y / 2);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [30:0]        kx_step_r, ky_step_r, time_step_r, mobility_r, giw_r;
  logic signed [31:0] coeff_outer_r, coeff_inner_r, bx_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kx_step_r     <= '0;
      ky_step_r     <= '0;
      time_step_r   <= '0;
      mobility_r    <= ONE_Q31;
      coeff_outer_r <= '0;
      coeff_inner_r <= '0;
      bx_gain_r     <= '0;
      giw_r         <= ONE_Q31;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KX_STEP:     kx_step_r     <= cfg_wdata[30:0];
        REG_KY_STEP:     ky_step_r     <= cfg_wdata[30:0];
        REG_TIME_STEP:   time_step_r   <= cfg_wdata[30:0];
        REG_MOBILITY:    mobility_r    <= cfg_wdata[30:0];
        REG_COEFF_OUTER: coeff_outer_r <= cfg_wdata;
        REG_COEFF_INNER: coeff_inner_r <= cfg_wdata;
        REG_BX_GAIN:     bx_gain_r     <= cfg_wdata;
        REG_GAUSS_INV_W: giw_r         <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipe advances unless the output register is stuck.
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // valid bits for stages A..M, payload shift line for A..L
  logic       vld_r [0:12];
  pay_t       pay_r [0:11];

  // ---------------------------------------------------------------------------
  // Stage A: capture item
  // ---------------------------------------------------------------------------
  logic [9:0] a_col_r, a_row_r;

  // Stage B: wave numbers and dt*alpha
  logic [YW_W-1:0]  row_w, yk_w;
  logic [YK_W-1:0]  yk;
  logic [40:0]      kxp;
  logic [YK_W+30:0] kyp;
  logic [61:0]      dap;
  logic [63:0]      dar;
  logic [30:0]      b_kx_nxt, b_ky_nxt, b_da_nxt;
  logic             b_ov_nxt;
  logic [30:0]      b_kx_r, b_ky_r, b_da_r;
  logic             b_ov_r;

  assign row_w = YW_W'(a_row_r);
  assign yk_w  = (row_w >= HALF_W) ? ((row_w >= GRID_W) ? row_w - GRID_W : GRID_W - row_w)
                                   : row_w;
  assign yk    = yk_w[YK_W-1:0];
  assign kxp   = a_col_r * kx_step_r;
  assign kyp   = yk * ky_step_r;
  assign dap   = time_step_r * mobility_r;
  assign dar   = (64'(dap) + 64'd32768) >> 16;
  assign b_kx_nxt = sat_u31(64'(kxp));
  assign b_ky_nxt = sat_u31(64'(kyp));
  assign b_da_nxt = sat_u31(dar);
  assign b_ov_nxt = (|kxp[40:31]) || (|kyp[YK_W+30:31]) || (|dar[63:31]);

  // Stage C: squares of the wave numbers
  logic [61:0] c_kxx_r, c_kyy_r;
  logic [30:0] c_da_r;
  logic        c_ov_r;

  // Stage D: k2
  logic [63:0] k2_sum;
  logic [30:0] d_k2_r, d_da_r;
  logic        d_ov_r;
  assign k2_sum = ((64'(c_kxx_r) + 64'd32768) >> 16) + ((64'(c_kyy_r) + 64'd32768) >> 16);

  // Stage E: products on k2
  logic [61:0] e_ep_r, e_kk_r, e_gp_r;
  logic [30:0] e_k2_r;
  logic        e_ov_r;

  // Stage F: Gaussian exponent, polynomial, g
  logic [63:0]        epr, kkr, gpr;
  logic signed [63:0] polyw;
  logic [30:0]        f_e_r, f_g_r;
  logic signed [31:0] f_poly_r;
  logic               f_ov_r;
  assign epr   = (64'(e_ep_r) + 64'd32768) >> 16;
  assign kkr   = (64'(e_kk_r) + 64'd32768) >> 16;
  assign gpr   = (64'(e_gp_r) + 64'd32768) >> 16;
  assign polyw = $signed(kkr) - $signed({32'd0, e_k2_r, 1'b0});

  // Stage G: exponent to base 2, bx*poly
  logic [47:0]        g_yp_r;
  logic signed [63:0] g_pb_r;
  logic [30:0]        g_g_r;
  logic               g_ov_r;

  // Stage H: table lookup
  logic [63:0]        yr;
  logic [3:0]         tidx;
  logic [16:0]        ta, tb;
  logic signed [63:0] mbr;
  logic [16:0]        h_a_r, h_d_r;
  logic [11:0]        h_rem_r;
  logic [4:0]         h_n_r;
  logic               h_chz_r;
  logic signed [47:0] h_mb_r;
  logic [30:0]        h_g_r;
  logic               h_ov_r;
  assign yr   = (64'(g_yp_r) + 64'd32768) >> 16;
  assign tidx = yr[15:12];
  assign ta   = pow2_tab({1'b0, tidx});
  assign tb   = pow2_tab(5'({1'b0, tidx}) + 5'd1);
  assign mbr  = (g_pb_r + 64'sd32768) >>> 16;

  // Stage I: interpolate and shift -> chi
  logic [29:0]        interp;
  logic [16:0]        chi_v, chi_nxt;
  logic [16:0]        i_chi_r;
  logic signed [47:0] i_mb_r;
  logic [30:0]        i_g_r;
  logic               i_ov_r;
  assign interp  = (30'(h_d_r) * 30'(h_rem_r) + 30'd2048) >> 12;
  assign chi_v   = h_a_r - interp[16:0];
  assign chi_nxt = h_chz_r ? 17'd0 : (chi_v >> h_n_r);

  // Stage J: weighted coefficients
  logic [16:0]        om;
  logic signed [49:0] j_po_r, j_pi_r;
  logic signed [47:0] j_mb_r;
  logic [30:0]        j_g_r;
  logic               j_ov_r;
  assign om = CHI_ONE - i_chi_r;

  // Stage K: linear operator L
  logic signed [63:0] po64, pi64, mb64, lsum;
  logic signed [31:0] k_lin_r;
  logic [30:0]        k_g_r;
  logic               k_ov_r;
  assign po64 = j_po_r;
  assign pi64 = j_pi_r;
  assign mb64 = j_mb_r;
  assign lsum = ((po64 + 64'sd32768) >>> 16) + ((pi64 + 64'sd32768) >>> 16) + mb64;

  // Stage L: g*L and g*nl
  logic signed [63:0] l_gl_r, l_gnr_r, l_gni_r;
  logic               l_ov_r;

  // Stage M: divisor and numerators
  logic signed [63:0] denw, numrw, numiw;
  logic signed [31:0] m_den_r, m_nre_r, m_nim_r;
  logic               m_ov_r;
  assign denw  = 64'sd65536 + ((l_gl_r + 64'sd32768) >>> 16);
  assign numrw = 64'(pay_r[11].s_re) - ((l_gnr_r + 64'sd32768) >>> 16);
  assign numiw = 64'(pay_r[11].s_im) - ((l_gni_r + 64'sd32768) >>> 16);

  // ---------------------------------------------------------------------------
  // Divider: stage 0 sets up, stages 1..32 produce one quotient bit each
  // ---------------------------------------------------------------------------
  logic        dv_vld_r  [0:DIV_BITS];
  logic [31:0] dv_dm_r   [0:DIV_BITS];
  dv_side_t    dv_side_r [0:DIV_BITS];
  logic [31:0] dv_rem_r  [0:DIV_BITS][0:1];
  logic [31:0] dv_w_r    [0:DIV_BITS][0:1];

  logic [31:0] dv_trial   [0:DIV_BITS-1][0:1];
  logic [31:0] dv_rem_nxt [0:DIV_BITS-1][0:1];
  logic [31:0] dv_w_nxt   [0:DIV_BITS-1][0:1];
  logic        dv_ge      [0:DIV_BITS-1][0:1];

  // set-up of stage 0 from M
  logic [31:0] dm0;
  logic [31:0] mag0 [0:1];
  logic [47:0] nd0  [0:1];
  logic signed [31:0] num0 [0:1];
  dv_side_t    side0;

  assign num0[0] = m_nre_r;
  assign num0[1] = m_nim_r;
  assign dm0     = m_den_r[31] ? 32'(-m_den_r) : 32'(m_den_r);

  always_comb begin
    side0      = '0;
    side0.ov   = m_ov_r;
    side0.dz   = (m_den_r == 32'sd0);
    side0.dneg = m_den_r[31];
    for (int l = 0; l < 2; l++) begin
      mag0[l]        = num0[l][31] ? 32'(-num0[l]) : 32'(num0[l]);
      // rounding: add half the divisor before dividing
      nd0[l]         = {mag0[l], 16'd0} + 48'(dm0 >> 1);
      side0.nneg[l]  = num0[l][31];
      side0.nzero[l] = (num0[l] == 32'sd0);
      side0.ovq[l]   = (32'(nd0[l][47:32]) >= dm0);
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_BITS; k++) begin
      for (int l = 0; l < 2; l++) begin
        dv_trial[k][l]   = {dv_rem_r[k][l][30:0], dv_w_r[k][l][31]};
        dv_ge[k][l]      = (dv_trial[k][l] >= dv_dm_r[k]);
        dv_rem_nxt[k][l] = dv_ge[k][l] ? dv_trial[k][l] - dv_dm_r[k] : dv_trial[k][l];
        dv_w_nxt[k][l]   = {dv_w_r[k][l][30:0], dv_ge[k][l]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final sign, saturation and zero-divisor handling
  // ---------------------------------------------------------------------------
  dv_side_t           fs;
  logic [31:0]        fq  [0:1];
  logic signed [31:0] res [0:1];
  logic [1:0]         rov;
  logic               fneg;

  assign fs = dv_side_r[DIV_BITS];

  always_comb begin
    fneg = 1'b0;
    for (int l = 0; l < 2; l++) begin
      fq[l] = dv_w_r[DIV_BITS][l];
      fneg  = fs.nneg[l] ^ fs.dneg;
      if (fs.dz) begin
        res[l] = fs.nzero[l] ? 32'sd0 : (fs.nneg[l] ? S32_MIN : S32_MAX);
        rov[l] = 1'b1;
      end else if (!fneg) begin
        rov[l] = fs.ovq[l] || fq[l][31];
        res[l] = rov[l] ? S32_MAX : $signed(fq[l]);
      end else begin
        rov[l] = fs.ovq[l] || (fq[l] > 32'h8000_0000);
        res[l] = rov[l] ? S32_MIN : $signed(32'(-fq[l]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits (reset) and data registers (no reset), all held on stall
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= 12; s++) vld_r[s] <= 1'b0;
      for (int k = 0; k <= DIV_BITS; k++) dv_vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s <= 12; s++) vld_r[s] <= vld_r[s-1];
      dv_vld_r[0] <= vld_r[12];
      for (int k = 1; k <= DIV_BITS; k++) dv_vld_r[k] <= dv_vld_r[k-1];
      out_valid_r <= dv_vld_r[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // A
      a_col_r      <= in_col_index;
      a_row_r      <= in_row_index;
      pay_r[0]     <= '{s_re: in_spec_re, s_im: in_spec_im, n_re: in_nl_re, n_im: in_nl_im};
      for (int s = 1; s <= 11; s++) pay_r[s] <= pay_r[s-1];
      // B
      b_kx_r <= b_kx_nxt;
      b_ky_r <= b_ky_nxt;
      b_da_r <= b_da_nxt;
      b_ov_r <= b_ov_nxt;
      // C
      c_kxx_r <= b_kx_r * b_kx_r;
      c_kyy_r <= b_ky_r * b_ky_r;
      c_da_r  <= b_da_r;
      c_ov_r  <= b_ov_r;
      // D
      d_k2_r <= sat_u31(k2_sum);
      d_da_r <= c_da_r;
      d_ov_r <= c_ov_r || (|k2_sum[63:31]);
      // E
      e_ep_r <= d_k2_r * giw_r;
      e_kk_r <= d_k2_r * d_k2_r;
      e_gp_r <= d_da_r * d_k2_r;
      e_k2_r <= d_k2_r;
      e_ov_r <= d_ov_r;
      // F: exponent clamps silently
      f_e_r    <= sat_u31(epr);
      f_poly_r <= sat_s32(polyw);
      f_g_r    <= sat_u31(gpr);
      f_ov_r   <= e_ov_r || ovf_s32(polyw) || (|gpr[63:31]);
      // G
      g_yp_r <= f_e_r * LOG2E_Q;
      g_pb_r <= bx_gain_r * f_poly_r;
      g_g_r  <= f_g_r;
      g_ov_r <= f_ov_r;
      // H
      h_a_r   <= ta;
      h_d_r   <= ta - tb;
      h_rem_r <= yr[11:0];
      h_n_r   <= yr[20:16];
      h_chz_r <= (yr[63:16] > 48'd16);
      h_mb_r  <= mbr[47:0];
      h_g_r   <= g_g_r;
      h_ov_r  <= g_ov_r;
      // I
      i_chi_r <= chi_nxt;
      i_mb_r  <= h_mb_r;
      i_g_r   <= h_g_r;
      i_ov_r  <= h_ov_r;
      // J
      j_po_r <= coeff_outer_r * $signed({1'b0, om});
      j_pi_r <= coeff_inner_r * $signed({1'b0, i_chi_r});
      j_mb_r <= i_mb_r;
      j_g_r  <= i_g_r;
      j_ov_r <= i_ov_r;
      // K
      k_lin_r <= sat_s32(lsum);
      k_g_r   <= j_g_r;
      k_ov_r  <= j_ov_r || ovf_s32(lsum);
      // L
      l_gl_r  <= $signed({1'b0, k_g_r}) * k_lin_r;
      l_gnr_r <= $signed({1'b0, k_g_r}) * pay_r[10].n_re;
      l_gni_r <= $signed({1'b0, k_g_r}) * pay_r[10].n_im;
      l_ov_r  <= k_ov_r;
      // M
      m_den_r <= sat_s32(denw);
      m_nre_r <= sat_s32(numrw);
      m_nim_r <= sat_s32(numiw);
      m_ov_r  <= l_ov_r || ovf_s32(denw) || ovf_s32(numrw) || ovf_s32(numiw);
      // divider set-up
      dv_dm_r[0]   <= dm0;
      dv_side_r[0] <= side0;
      for (int l = 0; l < 2; l++) begin
        dv_rem_r[0][l] <= 32'(nd0[l][47:32]);
        dv_w_r[0][l]   <= nd0[l][31:0];
      end
      // divider bit stages
      for (int k = 0; k < DIV_BITS; k++) begin
        dv_dm_r[k+1]   <= dv_dm_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
        for (int l = 0; l < 2; l++) begin
          dv_rem_r[k+1][l] <= dv_rem_nxt[k][l];
          dv_w_r[k+1][l]   <= dv_w_nxt[k][l];
        end
      end
      // output register
      out_new_re   <= res[0];
      out_new_im   <= res[1];
      out_overflow <= fs.ov || (|rov);
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: dv/tb_spectral_semi_implicit_update_top.sv
// Testbench for spectral_semi_implicit_update_top: streams spectral points through the
// update pipeline across several register settings and checks every result item.
// Depends on spsi_pkg and the top-level RTL.
`timescale 1ns / 100ps

module tb_spectral_semi_implicit_update_top
  import spsi_pkg::*;
;

  localparam int  GRID_H   = 1024;
  localparam int  DRAIN    = 60;       // margin beyond the pipeline depth
  localparam int  LIMIT    = 400000;   // generous cap on total cycles
  localparam int  HOLD_LEN = 300;      // long receiver hold-off

  typedef struct {
    logic [9:0]         col;
    logic [9:0]         row;
    logic signed [31:0] s_re;
    logic signed [31:0] s_im;
    logic signed [31:0] n_re;
    logic signed [31:0] n_im;
  } point_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ov;
  } update_t;

  // Holds the register copy, computes the expected updated coefficient for
  // each accepted point and checks result items against them in order.
  class update_scoreboard;
    longint  regs[8];
    update_t pending_q[$];
    int      errors;
    longint  pow2[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
                          44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

    function void reset_regs();
      foreach (regs[i]) regs[i] = 0;
      regs[REG_MOBILITY]    = 65536;
      regs[REG_GAUSS_INV_W] = 65536;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      if (idx inside {REG_COEFF_OUTER, REG_COEFF_INNER, REG_BX_GAIN})
        regs[idx] = longint'(signed'(v));
      else
        regs[idx] = longint'(v[30:0]);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Q16.16 product, round half up (floor of biased value)
    function longint qmul(longint a, longint b);
      return (a * b + 32768) >>> 16;
    endfunction

    function longint clamp32(longint v, inout bit ov);
      if (v > 64'sd2147483647) begin
        ov = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        ov = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint gauss_weight(longint k2);
      longint e, y, n, f, idx, rem, a, b, v;
      e = qmul(k2, regs[REG_GAUSS_INV_W]);
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      y = qmul(e, 94548);
      n = y >> 16;
      if (n > 16) return 0;
      f   = y & 16'hffff;
      idx = f >> 12;
      rem = f & 12'hfff;
      a = pow2[idx];
      b = pow2[idx + 1];
      v = a - (((a - b) * rem + 2048) >> 12);
      return v >> n;
    endfunction

    function longint divide_q(longint num, longint den, inout bit ov);
      longint mag, dm, q;
      if (den == 0) begin
        ov = 1;
        return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
      end
      mag = (num < 0 ? -num : num) * 65536;
      dm  = den < 0 ? -den : den;
      q   = (mag + dm / 2) / dm;
      return clamp32(((num < 0) != (den < 0)) ? -q : q, ov);
    endfunction

    function update_t predict(point_t p);
      update_t r;
      bit ov;
      longint yk, kx, ky, k2, chi, poly, lin, da, g, den, num_re, num_im;
      ov = 0;
      yk = longint'(p.row);
      if (yk >= GRID_H / 2) yk = yk - GRID_H;
      if (yk < 0) yk = -yk;
      kx   = clamp32(longint'(p.col) * regs[REG_KX_STEP], ov);
      ky   = clamp32(yk * regs[REG_KY_STEP], ov);
      k2   = clamp32(qmul(kx, kx) + qmul(ky, ky), ov);
      chi  = gauss_weight(k2);
      poly = clamp32(qmul(k2, k2) - 2 * k2, ov);
      lin  = clamp32(qmul(regs[REG_COEFF_OUTER], 65536 - chi)
                     + qmul(regs[REG_COEFF_INNER], chi)
                     + qmul(regs[REG_BX_GAIN], poly), ov);
      da   = clamp32(qmul(regs[REG_TIME_STEP], regs[REG_MOBILITY]), ov);
      g    = clamp32(qmul(da, k2), ov);
      den  = clamp32(65536 + qmul(g, lin), ov);
      num_re = clamp32(longint'(p.s_re) - qmul(g, longint'(p.n_re)), ov);
      num_im = clamp32(longint'(p.s_im) - qmul(g, longint'(p.n_im)), ov);
      r.re = 32'(divide_q(num_re, den, ov));
      r.im = 32'(divide_q(num_im, den, ov));
      r.ov = ov;
      return r;
    endfunction

    function void note_input(point_t p);
      pending_q.push_back(predict(p));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(logic signed [31:0] re, logic signed [31:0] im, logic ov);
      update_t x;
      if (pending_q.size() == 0) begin
        report("unexpected item", re, 0);
        return;
      end
      x = pending_q.pop_front();
      if (re !== x.re) report("new_re", re, x.re);
      if (im !== x.im) report("new_im", im, x.im);
      if (ov !== x.ov) report("overflow", 32'(ov), 32'(x.ov));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [9:0]         in_col_index;
  logic [9:0]         in_row_index;
  logic signed [31:0] in_spec_re;
  logic signed [31:0] in_spec_im;
  logic signed [31:0] in_nl_re;
  logic signed [31:0] in_nl_im;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_new_re;
  logic signed [31:0] out_new_im;
  logic               out_overflow;

  update_scoreboard sb;
  int  cycles;
  bit  allow_idle;   // random bursts on both sides; cleared for the final stretch
  bit  hold_req;     // ask the receiver for one long hold-off

  spectral_semi_implicit_update_top dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_col_index, .in_row_index,
    .in_spec_re, .in_spec_im, .in_nl_re, .in_nl_im,
    .out_valid, .out_ready, .out_new_re, .out_new_im, .out_overflow
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Sample both handshakes at the rising edge; inputs only move on the falling edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready)
      sb.note_input('{in_col_index, in_row_index, in_spec_re, in_spec_im, in_nl_re, in_nl_im});
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_new_re, out_new_im, out_overflow);
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: ready by default, random stall bursts, and one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 0;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one item, optionally after an idle burst; return on the falling edge
  // after it was accepted so the next item can follow back to back.
  task send_point(point_t p);
    if (allow_idle && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_col_index <= p.col;
    in_row_index <= p.row;
    in_spec_re   <= p.s_re;
    in_spec_im   <= p.s_im;
    in_nl_re     <= p.n_re;
    in_nl_im     <= p.n_im;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain the pipeline, then write all eight registers on consecutive cycles.
  task program_regs(logic [31:0] v[8]);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= v[i];
      sb.write_reg(3'(i), v[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
      1, 2: return 32'(int'($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function point_t random_point();
    point_t p;
    p.col  = $urandom_range(0, 9) == 0 ? 10'($urandom_range(513, 1023))
                                       : 10'($urandom_range(0, 512));
    p.row  = 10'($urandom_range(0, 1023));
    p.s_re = pick_value();
    p.s_im = pick_value();
    p.n_re = pick_value();
    p.n_im = pick_value();
    return p;
  endfunction

  // Physically sensible settings: small wave-number steps, small dt, modest coefficients.
  function void sane_regs(output logic [31:0] v[8]);
    v[REG_KX_STEP]     = $urandom_range(50, 800);
    v[REG_KY_STEP]     = $urandom_range(50, 800);
    v[REG_TIME_STEP]   = $urandom_range(0, 3000);
    v[REG_MOBILITY]    = $urandom_range(16384, 131072);
    v[REG_COEFF_OUTER] = 32'(int'($urandom_range(0, 262143)) - 131072);
    v[REG_COEFF_INNER] = 32'(int'($urandom_range(0, 262143)) - 131072);
    v[REG_BX_GAIN]     = 32'(int'($urandom_range(0, 131071)) - 65536);
    v[REG_GAUSS_INV_W] = $urandom_range(0, 262144);
  endfunction

  task random_points(int count);
    for (int i = 0; i < count; i++) send_point(random_point());
  endtask

  initial begin
    logic [31:0] regv[8];
    point_t      p;
    sb = new();
    sb.reset_regs();
    cycles       = 0;
    allow_idle   = 1;
    hold_req     = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_col_index = '0;
    in_row_index = '0;
    in_spec_re   = '0;
    in_spec_im   = '0;
    in_nl_re     = '0;
    in_nl_im     = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: g is zero, so each point passes through unchanged.
    random_points(100);

    // Directed points under sensible settings: column and row extremes,
    // the negative-frequency wrap, oversized columns and extreme input values.
    sane_regs(regv);
    regv[REG_TIME_STEP] = 3000;
    program_regs(regv);
    foreach (regv[i]) begin
      p.col = i % 2 ? 10'd512 : 10'd0;
    end
    for (int i = 0; i < 24; i++) begin
      case (i % 8)
        0: p.col = 10'd0;
        1: p.col = 10'd512;
        2: p.col = 10'd1023;
        3: p.col = 10'd511;
        default: p.col = 10'($urandom_range(0, 512));
      endcase
      case (i % 6)
        0: p.row = 10'd0;
        1: p.row = 10'd511;
        2: p.row = 10'd512;
        3: p.row = 10'd1023;
        4: p.row = 10'd513;
        default: p.row = 10'($urandom_range(0, 1023));
      endcase
      p.s_re = i < 8 ? S32_MAX : (i < 16 ? S32_MIN : 32'sd0);
      p.s_im = i < 8 ? S32_MIN : (i < 16 ? S32_MAX : 32'sd65536);
      p.n_re = i % 3 == 0 ? S32_MAX : (i % 3 == 1 ? S32_MIN : 32'sd0);
      p.n_im = i % 3 == 0 ? S32_MIN : (i % 3 == 1 ? S32_MAX : -32'sd1);
      send_point(p);
    end

    // Long receiver hold-off while the sender keeps offering: the pipeline fills
    // and in_ready must drop.
    hold_req = 1;
    random_points(250);

    // Fully random register values, mostly saturating paths.
    for (int j = 0; j < 8; j++) regv[j] = $urandom;
    program_regs(regv);
    random_points(220);

    // Upper extremes.
    regv = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    program_regs(regv);
    random_points(150);

    // Lower extremes: zero steps and the most negative coefficients.
    regv = '{32'h0, 32'h0, 32'h0, 32'h0,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0};
    program_regs(regv);
    random_points(100);

    // Negative bias on the operator so that the divisor crosses zero.
    sane_regs(regv);
    regv[REG_TIME_STEP]   = 65536;
    regv[REG_COEFF_OUTER] = 32'hffff_0000;
    regv[REG_COEFF_INNER] = 32'hfff0_0000;
    program_regs(regv);
    random_points(250);

    // Sensible settings again, and the last stretch back to back.
    sane_regs(regv);
    program_regs(regv);
    random_points(250);
    allow_idle = 0;
    sane_regs(regv);
    program_regs(regv);
    random_points(250);

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
